[rtl/core/mac_learning_table_with_aging_core_assert.svh]
// Assertion macros for the MAC learning table core.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef MAC_LEARNING_TABLE_WITH_AGING_CORE_ASSERT_SVH
`define MAC_LEARNING_TABLE_WITH_AGING_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlt assertion failed");

// Next-cycle implication, disabled during reset.
`define MLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlt assertion failed");

`endif

[rtl/core/mlt_pkg.sv]
// Shared types and constants for the MAC learning table core.
// No dependencies.
`timescale 1ns / 1ps
package mlt_pkg;
  localparam int BUCKETS_DEF = 256;
  localparam int WAYS_DEF    = 4;
  localparam int MAC_W       = 48;
  localparam int PORT_W      = 8;
  localparam int SEEN_W      = 16;
  localparam int AGE_W       = 15;
  localparam int AGED_W      = 11;
  localparam int MODE_W      = 3;
  localparam int STAT_W      = 2;
  localparam int HASH_W      = 8;

  localparam logic [AGE_W-1:0]  AGING_RST = 15'd5;
  localparam logic [AGED_W-1:0] AGED_MAX  = 11'd2047;

  localparam logic [MODE_W-1:0] MODE_LEARN  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SWEEP  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [MAC_W-1:0]  addr;
    logic [PORT_W-1:0] port;
    logic [SEEN_W-1:0] seen;
  } slot_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              hit;
    logic [PORT_W-1:0] found_port;
  } res_t;
endpackage

[rtl/core/mlt_ram.sv]
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module mlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/core/mlt_row_eval.sv]
// Bucket row evaluation: match, free-way pick, ageing and row update.
// Depends on mlt_pkg.
`timescale 1ns / 1ps
module mlt_row_eval import mlt_pkg::*; #(
  parameter int WAYS = WAYS_DEF
) (
  input  slot_t [WAYS-1:0]             row_i,
  input  logic [MODE_W-1:0]            mode_i,
  input  logic [MAC_W-1:0]             mac_i,
  input  logic [PORT_W-1:0]            port_i,
  input  logic [SEEN_W-1:0]            now_i,
  input  logic [AGE_W-1:0]             aging_i,
  output slot_t [WAYS-1:0]             row_o,
  output res_t                         res_o,
  output logic [$clog2(WAYS+1)-1:0]    aged_n_o
);
  localparam int AGN_W = $clog2(WAYS+1);

  logic [WAYS-1:0] match, free, old, sel_m, sel_f;
  logic            taken_m, taken_f, any_m, any_f;

  always_comb begin
    taken_m = 1'b0;
    taken_f = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row_i[w].valid && (row_i[w].addr == mac_i);
      free[w]  = !row_i[w].valid;
      old[w]   = row_i[w].valid && ((now_i - row_i[w].seen) > {1'b0, aging_i});
      sel_m[w] = match[w] && !taken_m;
      sel_f[w] = free[w] && !taken_f;
      taken_m  = taken_m | match[w];
      taken_f  = taken_f | free[w];
    end
    any_m = |match;
    any_f = |free;
  end

  always_comb begin
    row_o    = row_i;
    res_o    = '0;
    aged_n_o = '0;
    unique case (mode_i)
      MODE_LEARN: begin
        if (any_m) begin
          res_o.hit = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (sel_m[w]) begin
              row_o[w].port = port_i;
              row_o[w].seen = now_i;
            end
          end
        end else if (any_f) begin
          for (int w = 0; w < WAYS; w++) begin
            if (sel_f[w]) begin
              row_o[w] = '{valid: 1'b1, addr: mac_i, port: port_i, seen: now_i};
            end
          end
        end else begin
          res_o.status = STAT_FULL;
        end
      end
      MODE_LOOKUP: begin
        if (any_m) begin
          res_o.hit = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (sel_m[w]) begin
              res_o.found_port = row_i[w].port;
              row_o[w].seen    = now_i;
            end
          end
        end else begin
          res_o.status = STAT_MISS;
        end
      end
      MODE_DELETE: begin
        if (any_m) begin
          res_o.hit = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (sel_m[w]) begin
              row_o[w].valid = 1'b0;
            end
          end
        end else begin
          res_o.status = STAT_MISS;
        end
      end
      MODE_SWEEP: begin
        for (int w = 0; w < WAYS; w++) begin
          if (old[w]) begin
            row_o[w].valid = 1'b0;
          end
          aged_n_o = aged_n_o + AGN_W'(old[w]);
        end
      end
      default: begin
      end
    endcase
  end
endmodule

[rtl/core/mac_learning_table_with_aging_core.sv]
// MAC learning table with ageing: learn, lookup, delete, tick, age sweep.
// Learn/lookup/delete/tick: the bucket row is read on acceptance, then, once
// the result register is free, modified, written back and the result
// registered; input stalls until then. Age sweep: one bucket row per cycle
// through the RAM. Reset (synchronous, rst_n low): a clearing pass writes
// every row invalid; input stalls until it ends. Config writes always taken.
`timescale 1ns / 1ps
module mac_learning_table_with_aging_core import mlt_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS    = WAYS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input transactions
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [MAC_W-1:0]   in_mac,
  input  logic [PORT_W-1:0]  in_port,
  // result transactions
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  out_status,
  output logic               out_hit,
  output logic [PORT_W-1:0]  out_found_port,
  output logic [AGED_W-1:0]  out_aged_count,
  // ageing time register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [AGE_W-1:0]   cfg_aging_time
);
  `include "mac_learning_table_with_aging_core_assert.svh"

  localparam int BW    = $clog2(BUCKETS);
  localparam int RW    = WAYS * $bits(slot_t);
  localparam int AGN_W = $clog2(WAYS + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RESP  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_SDONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [BW-1:0]     clr_r, clr_nxt;
  logic [BW:0]       rd_ptr_r, rd_ptr_nxt;
  logic [BW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [MODE_W-1:0] op_mode_r, op_mode_nxt;
  logic [MAC_W-1:0]  op_mac_r, op_mac_nxt;
  logic [PORT_W-1:0] op_port_r, op_port_nxt;
  logic [BW-1:0]     op_bkt_r, op_bkt_nxt;
  logic [SEEN_W-1:0] sec_r, sec_nxt;
  logic [AGE_W-1:0]  aging_r, aging_nxt;
  logic [AGED_W-1:0] acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;
  logic [AGED_W-1:0] out_aged_r, out_aged_nxt;

  // RAM port signals
  logic          we, re;
  logic [BW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;

  slot_t [WAYS-1:0]  row_rd, row_new;
  res_t              ev_res;
  logic [AGN_W-1:0]  ev_aged;
  logic [MODE_W-1:0] ev_mode;
  logic [BW-1:0]     in_bkt;
  logic [HASH_W-1:0] hash_rem;
  logic              in_take, out_free, last_row;
  logic [AGED_W:0]   acc_sum;

  // Bucket from the low address byte, folded onto the bucket count by
  // compare and subtract of shifted bucket counts.
  always_comb begin
    hash_rem = in_mac[HASH_W-1:0];
    if (BUCKETS < (1 << HASH_W)) begin
      for (int k = HASH_W - 1; k >= 0; k--) begin
        if (((BUCKETS << k) < (1 << HASH_W)) && (hash_rem >= HASH_W'(BUCKETS << k))) begin
          hash_rem = hash_rem - HASH_W'(BUCKETS << k);
        end
      end
    end
    in_bkt = BW'(hash_rem);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign row_rd    = rdata;
  assign ev_mode   = (state_r == S_SWEEP) ? MODE_SWEEP : op_mode_r;
  assign last_row  = pend_r && (rd_ptr_r == (BW+1)'(BUCKETS));
  assign acc_sum   = {1'b0, acc_r} + (AGED_W+1)'(ev_aged);

  mlt_row_eval #(.WAYS(WAYS)) u_eval (
    .row_i    (row_rd),
    .mode_i   (ev_mode),
    .mac_i    (op_mac_r),
    .port_i   (op_port_r),
    .now_i    (sec_r),
    .aging_i  (aging_r),
    .row_o    (row_new),
    .res_o    (ev_res),
    .aged_n_o (ev_aged)
  );

  mlt_ram #(.WIDTH(RW), .DEPTH(BUCKETS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    pend_nxt      = pend_r;
    op_mode_nxt   = op_mode_r;
    op_mac_nxt    = op_mac_r;
    op_port_nxt   = op_port_r;
    op_bkt_nxt    = op_bkt_r;
    sec_nxt       = sec_r;
    aging_nxt     = cfg_valid ? cfg_aging_time : aging_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    out_aged_nxt  = out_aged_r;
    we            = 1'b0;
    waddr         = op_bkt_r;
    wdata         = row_new;
    re            = 1'b0;
    raddr         = in_bkt;

    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BW'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          op_mode_nxt = in_mode;
          op_mac_nxt  = in_mac;
          op_port_nxt = in_port;
          op_bkt_nxt  = in_bkt;
          if (in_mode == MODE_SWEEP) begin
            state_nxt  = S_SWEEP;
            rd_ptr_nxt = '0;
            pend_nxt   = 1'b0;
            acc_nxt    = '0;
          end else begin
            re        = 1'b1;
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          we            = (op_mode_r == MODE_LEARN) || (op_mode_r == MODE_LOOKUP) ||
                          (op_mode_r == MODE_DELETE);
          out_valid_nxt = 1'b1;
          out_res_nxt   = ev_res;
          out_aged_nxt  = '0;
          if (op_mode_r == MODE_TICK) begin
            sec_nxt = sec_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        // read row k while row k-1 is written back
        if (rd_ptr_r != (BW+1)'(BUCKETS)) begin
          re         = 1'b1;
          raddr      = rd_ptr_r[BW-1:0];
          rd_ptr_nxt = rd_ptr_r + 1'b1;
          wr_ptr_nxt = rd_ptr_r[BW-1:0];
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          we      = 1'b1;
          waddr   = wr_ptr_r;
          acc_nxt = (acc_sum > {1'b0, AGED_MAX}) ? AGED_MAX : acc_sum[AGED_W-1:0];
        end
        if (last_row) begin
          state_nxt = S_SDONE;
        end
      end
      S_SDONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '0;
          out_aged_nxt  = acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rd_ptr_r    <= '0;
      pend_r      <= 1'b0;
      sec_r       <= '0;
      aging_r     <= AGING_RST;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      pend_r      <= pend_nxt;
      sec_r       <= sec_nxt;
      aging_r     <= aging_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_ptr_r   <= wr_ptr_nxt;
    op_mode_r  <= op_mode_nxt;
    op_mac_r   <= op_mac_nxt;
    op_port_r  <= op_port_nxt;
    op_bkt_r   <= op_bkt_nxt;
    out_res_r  <= out_res_nxt;
    out_aged_r <= out_aged_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_hit        = out_res_r.hit;
  assign out_found_port = out_res_r.found_port;
  assign out_aged_count = out_aged_r;

  // A row is never read and written in the same cycle at the same address.
  `MLT_ASSERT_NOW(a_no_rw_clash, we && re, waddr != raddr)
  // An accepted transaction always moves into a working state.
  `MLT_ASSERT_NEXT(a_take_moves, in_take, (state_r == S_RESP) || (state_r == S_SWEEP))
  // The seconds counter only ever steps by one.
  `MLT_ASSERT_NOW(a_sec_step, $past(rst_n) && (sec_r != $past(sec_r)),
                  sec_r == $past(sec_r) + 1'b1)
endmodule

[verif/tb.sv]
// Self-checking testbench for mac_learning_table_with_aging_core.
// Depends on mlt_pkg and the core; a directed table, then random traffic.
`timescale 1ns / 1ps
module tb;
  import mlt_pkg::*;

  localparam int NBKT = 256;
  localparam int NWAY = 4;
  localparam int NRAND = 550;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [MODE_W-1:0] in_mode;
  logic [MAC_W-1:0] in_mac;
  logic [PORT_W-1:0] in_port;
  logic out_valid, out_stall;
  logic [STAT_W-1:0] out_status;
  logic out_hit;
  logic [PORT_W-1:0] out_found_port;
  logic [AGED_W-1:0] out_aged_count;
  logic cfg_valid, cfg_ready;
  logic [AGE_W-1:0] cfg_aging_time;

  mac_learning_table_with_aging_core DUT (.*);

  // One expected result transaction
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic hit;
    logic [PORT_W-1:0] found_port;
    logic [AGED_W-1:0] aged_count;
  } answer_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [MAC_W-1:0] mac;
    logic [PORT_W-1:0] port;
    bit typed;
    answer_t want;
  } row_t;

  // Shadow table
  bit tbl_valid [NBKT*NWAY];
  logic [MAC_W-1:0] tbl_mac [NBKT*NWAY];
  logic [PORT_W-1:0] tbl_port [NBKT*NWAY];
  logic [SEEN_W-1:0] tbl_seen [NBKT*NWAY];
  logic [SEEN_W-1:0] now_secs;
  logic [AGE_W-1:0] age_limit;

  answer_t answers_due[$];
  int errors, results_seen, sweeps_seen, fulls_seen;
  bit long_hold;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int find_way(input logic [MAC_W-1:0] m);
    int b;
    b = m[HASH_W-1:0] * NWAY;
    for (int w = 0; w < NWAY; w++)
      if (tbl_valid[b+w] && tbl_mac[b+w] == m) return b + w;
    return -1;
  endfunction

  // Predicts the answer and updates the shadow table
  function automatic answer_t table_step(input logic [MODE_W-1:0] mode,
                                         input logic [MAC_W-1:0] m, input logic [PORT_W-1:0] p);
    answer_t a;
    int s, b;
    logic [SEEN_W-1:0] age;
    a = '0;
    case (mode)
      MODE_LEARN: begin
        s = find_way(m);
        if (s >= 0) a.hit = 1;
        else begin
          b = m[HASH_W-1:0] * NWAY;
          for (int w = NWAY - 1; w >= 0; w--) if (!tbl_valid[b+w]) s = b + w;
        end
        if (s >= 0) begin
          tbl_valid[s] = 1; tbl_mac[s] = m; tbl_port[s] = p; tbl_seen[s] = now_secs;
        end else a.status = STAT_FULL;
      end
      MODE_LOOKUP: begin
        s = find_way(m);
        if (s >= 0) begin
          a.hit = 1; a.found_port = tbl_port[s]; tbl_seen[s] = now_secs;
        end else a.status = STAT_MISS;
      end
      MODE_DELETE: begin
        s = find_way(m);
        if (s >= 0) begin
          a.hit = 1; tbl_valid[s] = 0;
        end else a.status = STAT_MISS;
      end
      MODE_TICK: now_secs++;
      MODE_SWEEP: begin
        for (int i = 0; i < NBKT*NWAY; i++)
          if (tbl_valid[i]) begin
            age = now_secs - tbl_seen[i];
            if (age > age_limit) begin
              tbl_valid[i] = 0;
              if (a.aged_count != AGED_MAX) a.aged_count++;
            end
          end
      end
      default: ;
    endcase
    return a;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: stall pattern, with one long hold-off on request
  initial begin
    int hold;
    out_stall = 1;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1;
        hold++;
        if (hold > 300) begin
          long_hold = 0; hold = 0;
        end
      end else if (results_seen % 97 < 30)
        out_stall <= 0;  // stretch with no stall
      else
        out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Checker: accepted result against the oldest expectation
  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (answers_due.size() == 0) report("unexpected result", out_status, 0);
      else begin
        a = answers_due.pop_front();
        if (out_status !== a.status) report("status", out_status, a.status);
        if (out_hit !== a.hit) report("hit", out_hit, a.hit);
        if (out_found_port !== a.found_port) report("found_port", out_found_port, a.found_port);
        if (out_aged_count !== a.aged_count) report("aged_count", out_aged_count, a.aged_count);
        if (a.aged_count != 0) sweeps_seen++;
        if (a.status == STAT_FULL) fulls_seen++;
      end
    end
  end

  // Offers one transaction and waits for it to be taken
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [MAC_W-1:0] m,
                           input logic [PORT_W-1:0] p, input bit typed, input answer_t want);
    answer_t a;
    in_valid <= 1; in_mode <= mode; in_mac <= m; in_port <= p;
    do @(posedge clk); while (in_stall);
    a = table_step(mode, m, p);
    if (typed && a !== want) report("table row", a, want);
    answers_due.push_back(a);
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    int waited;
    in_valid <= 0;
    while (answers_due.size() != 0 && waited < 200000) begin
      @(posedge clk); waited++;
    end
    repeat (NBKT + 10) @(posedge clk);  // a sweep may still be in flight
  endtask

  task automatic write_aging(input logic [AGE_W-1:0] v);
    cfg_valid <= 1; cfg_aging_time <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    age_limit = v;
  endtask

  // Station address: a few buckets, mostly reused addresses
  function automatic logic [MAC_W-1:0] pick_mac;
    logic [MAC_W-1:0] m;
    m = MAC_W'({$urandom, $urandom});
    m[HASH_W-1:0] = HASH_W'($urandom_range(0, 5));
    if ($urandom_range(0, 3) != 0) m[MAC_W-1:HASH_W] = (MAC_W-HASH_W)'($urandom_range(0, 7));
    return m;
  endfunction

  row_t plan[$];

  function automatic row_t row(input logic [MODE_W-1:0] mode, input logic [MAC_W-1:0] m,
                               input logic [PORT_W-1:0] p, input bit typed,
                               input logic [STAT_W-1:0] st, input logic h,
                               input logic [PORT_W-1:0] fp, input logic [AGED_W-1:0] ag);
    row_t r;
    r.mode = mode; r.mac = m; r.port = p; r.typed = typed;
    r.want = '{status: st, hit: h, found_port: fp, aged_count: ag};
    return r;
  endfunction

  initial begin
    logic [MODE_W-1:0] mode;
    rst_n = 0; in_valid = 0; in_mode = 0; in_mac = 0; in_port = 0;
    cfg_valid = 0; cfg_aging_time = 0;
    now_secs = 0; age_limit = AGING_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // Directed table; expectations typed in only where obvious
    plan.push_back(row(MODE_LOOKUP, 48'h0, 0, 1, STAT_MISS, 0, 0, 0));
    plan.push_back(row(MODE_DELETE, '1, 0, 1, STAT_MISS, 0, 0, 0));
    plan.push_back(row(MODE_LEARN, '1, 8'hff, 1, STAT_OK, 0, 0, 0));
    plan.push_back(row(MODE_LOOKUP, '1, 0, 1, STAT_OK, 1, 8'hff, 0));
    plan.push_back(row(MODE_LEARN, 48'h0, 8'h00, 1, STAT_OK, 0, 0, 0));
    plan.push_back(row(MODE_LEARN, 48'h1_00, 8'h11, 1, STAT_OK, 0, 0, 0));
    plan.push_back(row(MODE_LEARN, 48'h2_00, 8'h22, 1, STAT_OK, 0, 0, 0));
    plan.push_back(row(MODE_LEARN, 48'h3_00, 8'h33, 1, STAT_OK, 0, 0, 0));
    plan.push_back(row(MODE_LEARN, 48'h4_00, 8'h44, 1, STAT_FULL, 0, 0, 0));   // bucket full
    plan.push_back(row(MODE_LEARN, 48'h1_00, 8'h55, 1, STAT_OK, 1, 0, 0));     // refresh
    plan.push_back(row(MODE_DELETE, 48'h2_00, 0, 1, STAT_OK, 1, 0, 0));
    plan.push_back(row(MODE_LEARN, 48'h4_00, 8'h44, 1, STAT_OK, 0, 0, 0));     // reuses way
    plan.push_back(row(MODE_LOOKUP, 48'h1_00, 0, 1, STAT_OK, 1, 8'h55, 0));
    plan.push_back(row(3'd5, '1, 8'hff, 1, 0, 0, 0, 0));
    plan.push_back(row(3'd7, 48'h5555_5555_5555, 8'haa, 1, 0, 0, 0, 0));
    plan.push_back(row(MODE_TICK, '1, 8'hff, 1, STAT_OK, 0, 0, 0));
    plan.push_back(row(MODE_SWEEP, '1, 8'hff, 1, STAT_OK, 0, 0, 0));  // age 1, nothing goes
    for (int i = 0; i < 5; i++) plan.push_back(row(MODE_TICK, 0, 0, 1, STAT_OK, 0, 0, 0));
    plan.push_back(row(MODE_LOOKUP, 48'h0, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(MODE_SWEEP, 48'haaaa_aaaa_aaaa, 8'h55, 0, 0, 0, 0, 0));
    plan.push_back(row(MODE_LOOKUP, '1, 0, 0, 0, 0, 0, 0));
    foreach (plan[i])
      send_item(plan[i].mode, plan[i].mac, plan[i].port, plan[i].typed, plan[i].want);
    drain();

    // Random phases at several ageing times, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_aging(15'd1);
        1: write_aging(15'h7fff);
        2: write_aging(15'd0);
        3: write_aging(15'h5555);
        default: write_aging(15'd3);
      endcase
      if (ph == 1) long_hold = 1;  // receiver holds off while we keep sending
      for (int n = 0; n < NRAND / 5; ) begin
        int burst;
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && n < NRAND / 5; k++, n++) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: mode = MODE_LEARN;
            7, 8, 9, 10, 11: mode = MODE_LOOKUP;
            12, 13, 14: mode = MODE_DELETE;
            15, 16: mode = MODE_TICK;
            17: mode = MODE_SWEEP;
            default: mode = 3'($urandom_range(0, 7));
          endcase
          send_item(mode,
                    ($urandom_range(0, 30) == 0) ? MAC_W'({$urandom, $urandom}) : pick_mac(),
                    8'($urandom), 0, '0);
        end
        if (n == NRAND / 10) drain();  // sender waits for every result
        else if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
      drain();
    end

    $display("covered %0d results, %0d sweeps removing entries, %0d full-bucket learns",
             results_seen, sweeps_seen, fulls_seen);
    if (errors == 0 && answers_due.size() == 0)
      $display("PASS mac_learning_table_with_aging_core");
    else
      $display("FAIL mac_learning_table_with_aging_core");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL mac_learning_table_with_aging_core");
    $finish;
  end
endmodule
